// ----- hdl/fqs_pkg.sv -----
package fqs_pkg;

	localparam int CMD_W               = 3;
	localparam int LEN_FIELD_W         = 16;
	localparam int STATUS_W            = 2;
	localparam int AVG_W               = 32;
	localparam int OCC_W               = 9;
	localparam int FRAC_W              = 16;
	localparam int DEFAULT_QUEUE_DEPTH = 256;
	localparam int DEFAULT_LENGTH_BITS = 16;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_ENQ = 3'd0;
	localparam cmd_t CMD_DEQ = 3'd1;
	localparam cmd_t CMD_AVG = 3'd2;
	localparam cmd_t CMD_MIN = 3'd3;
	localparam cmd_t CMD_MAX = 3'd4;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_EMPTY   = 2'd1;
	localparam status_t STAT_FULL    = 2'd2;
	localparam status_t STAT_INVALID = 2'd3;

endpackage

// ----- hdl/fqs_if.sv -----
interface fqs_cmd_if import fqs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       command;
	logic [LEN_FIELD_W-1:0] length_in;

	modport source (output valid, output command, output length_in, input ready);
	modport sink   (input valid, input command, input length_in, output ready);
endinterface

interface fqs_rsp_if import fqs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [LEN_FIELD_W-1:0] result_value;
	logic [AVG_W-1:0]       average_fixed;
	logic [OCC_W-1:0]       occupancy;

	modport source (output valid, output status, output result_value,
		output average_fixed, output occupancy, input ready);
	modport sink   (input valid, input status, input result_value,
		input average_fixed, input occupancy, output ready);
endinterface

// ----- hdl/fqs_mem.sv -----
module fqs_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/fqs_div.sv -----
module fqs_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 9,
	localparam int CNT_W = $clog2(NUM_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// restoring divide, one quotient bit per cycle
	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- hdl/fifo_queue_with_length_statistics_core.sv -----
// Queue of message lengths with average, minimum and maximum queries. One command is taken at
// a time; each gives one response that also reports the occupancy after the command. Enqueue,
// invalid commands and any command that finds the queue empty (or full, for enqueue) go
// straight to S_DONE; dequeue passes S_DEQ first. Minimum and maximum walk the stored entries
// through the single read port of the entry RAM, reading each entry in turn. The average runs a
// one-bit-per-cycle restoring divider over the running total with 16 fraction bits. The next
// command is taken while the previous response still waits in the output register.
module fifo_queue_with_length_statistics_core import fqs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
	parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	fqs_cmd_if.sink   cmd,
	fqs_rsp_if.source rsp
);

	localparam int LEN_W = (LENGTH_BITS < LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TOT_W = LEN_W + CNT_W;
	localparam int NUM_W = TOT_W + FRAC_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEQ  = 5'b00010,
		S_SCAN = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [TOT_W-1:0] total_q;
	logic [PTR_W-1:0] scan_ptr_q;
	logic [CNT_W-1:0] scan_left_q;
	logic             rd_pend_q;
	logic             scan_first_q;
	logic             rsp_valid_q;

	cmd_t             cmd_q;
	status_t          status_q;
	logic [LEN_W-1:0] value_q;
	logic [AVG_W-1:0] avg_q;

	status_t                rsp_status_q;
	logic [LEN_FIELD_W-1:0] rsp_value_q;
	logic [AVG_W-1:0]       rsp_avg_q;
	logic [OCC_W-1:0]       rsp_occ_q;

	logic             accept;
	cmd_t             cmd_code;
	logic [LEN_W-1:0] len_in;
	logic             is_invalid;
	logic             full;
	logic             empty;
	logic             out_free;
	logic [PTR_W-1:0] head_nxt;
	logic [PTR_W-1:0] tail_nxt;
	logic [PTR_W-1:0] scan_nxt;
	logic             mem_we;
	logic             mem_re;
	logic [PTR_W-1:0] mem_raddr;
	logic [LEN_W-1:0] mem_rdata;
	logic             div_start;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;
	logic             better;

	assign cmd.ready  = (state_q == S_IDLE);
	assign accept     = cmd.valid && cmd.ready;
	assign cmd_code   = cmd.command;
	assign len_in     = cmd.length_in[LEN_W-1:0];
	assign is_invalid = !(cmd_code inside {[CMD_ENQ:CMD_MAX]});
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign out_free   = !rsp_valid_q || rsp.ready;

	assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_nxt = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
	assign scan_nxt = (scan_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : scan_ptr_q + PTR_W'(1);

	// a write and a read of one slot never share a cycle: every command passes S_DONE
	assign mem_we    = accept && (cmd_code == CMD_ENQ) && !full;
	assign mem_re    = (accept && (cmd_code == CMD_DEQ) && !empty)
		|| ((state_q == S_SCAN) && (scan_left_q != '0));
	assign mem_raddr = (state_q == S_SCAN) ? scan_ptr_q : head_q;
	assign div_start = accept && (cmd_code == CMD_AVG) && !empty;

	assign better = (cmd_q == CMD_MAX) ? (mem_rdata > value_q) : (mem_rdata < value_q);

	fqs_mem #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (LEN_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (len_in),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fqs_div #(
		.NUM_W (NUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({total_q, FRAC_W'(0)}),
		.den    (count_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			rd_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_invalid) begin
							state_q <= S_DONE;
						end else if (cmd_code == CMD_ENQ) begin
							if (!full) begin
								tail_q  <= tail_nxt;
								count_q <= count_q + CNT_W'(1);
								total_q <= total_q + TOT_W'(len_in);
							end
							state_q <= S_DONE;
						end else if (empty) begin
							state_q <= S_DONE;
						end else begin
							case (cmd_code)
								CMD_DEQ: state_q <= S_DEQ;
								CMD_AVG: state_q <= S_DIV;
								default: begin
									scan_ptr_q  <= head_q;
									scan_left_q <= count_q;
									rd_pend_q   <= 1'b0;
									state_q     <= S_SCAN;
								end
							endcase
						end
					end
				end
				S_DEQ: begin
					head_q  <= head_nxt;
					count_q <= count_q - CNT_W'(1);
					total_q <= total_q - TOT_W'(mem_rdata);
					state_q <= S_DONE;
				end
				S_SCAN: begin
					rd_pend_q <= (scan_left_q != '0);
					if (scan_left_q != '0) begin
						scan_ptr_q  <= scan_nxt;
						scan_left_q <= scan_left_q - CNT_W'(1);
					end else if (!rd_pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= cmd_code;
					value_q      <= '0;
					avg_q        <= '0;
					scan_first_q <= 1'b1;
					if (is_invalid) begin
						status_q <= STAT_INVALID;
					end else if (cmd_code == CMD_ENQ) begin
						status_q <= full ? STAT_FULL : STAT_OK;
					end else begin
						status_q <= empty ? STAT_EMPTY : STAT_OK;
					end
				end
			end
			S_DEQ: value_q <= mem_rdata;
			S_SCAN: begin
				if (rd_pend_q) begin
					scan_first_q <= 1'b0;
					if (scan_first_q || better) begin
						value_q <= mem_rdata;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					avg_q <= AVG_W'(div_quot);
				end
			end
			S_DONE: begin
				if (out_free) begin
					rsp_status_q <= status_q;
					rsp_value_q  <= LEN_FIELD_W'(value_q);
					rsp_avg_q    <= avg_q;
					rsp_occ_q    <= OCC_W'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.result_value  = rsp_value_q;
	assign rsp.average_fixed = rsp_avg_q;
	assign rsp.occupancy     = rsp_occ_q;

endmodule

// ----- hdl/fqs_chk.sv -----
module fqs_chk import fqs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [STATUS_W-1:0]    status,
	input logic [LEN_FIELD_W-1:0] result_value,
	input logic [AVG_W-1:0]       average_fixed,
	input logic [OCC_W-1:0]       occupancy
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_FULL) |-> (occupancy == OCC_W'(QUEUE_DEPTH)))
		else $error("full status below queue depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |-> (result_value == '0) && (average_fixed == '0))
		else $error("nonzero values on failed transaction");

endmodule

bind fifo_queue_with_length_statistics_core fqs_chk #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.result_value  (rsp.result_value),
	.average_fixed (rsp.average_fixed),
	.occupancy     (rsp.occupancy)
);
